FILE: hdl/olm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// olm_pkg
// shared types, codes and sizes for the ordered list manager
// ----------------------------------------------------------------------------
package olm_pkg;

	localparam int OLM_CAPACITY = 32;
	localparam int VAL_W        = 32;
	localparam int OP_W         = 3;
	localparam int STAT_W       = 2;

	// request codes
	localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd0;
	localparam logic [OP_W-1:0] OP_INS_BACK  = 3'd1;
	localparam logic [OP_W-1:0] OP_INS_AFTER = 3'd2;
	localparam logic [OP_W-1:0] OP_DEL_FRONT = 3'd3;
	localparam logic [OP_W-1:0] OP_DEL_BACK  = 3'd4;
	localparam logic [OP_W-1:0] OP_DEL_VALUE = 3'd5;
	localparam logic [OP_W-1:0] OP_DUMP      = 3'd6;

	// status codes
	localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
	localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd1;
	localparam logic [STAT_W-1:0] STAT_NOTFOUND = 2'd2;
	localparam logic [STAT_W-1:0] STAT_FULL     = 2'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MATCH,
		ST_APPLY,
		ST_DUMP
	} olm_state_t;

	// what a cell loads at the next edge
	typedef enum logic [2:0] {
		CM_HOLD,
		CM_LOAD,
		CM_LEFT,
		CM_RIGHT,
		CM_HEAD
	} cell_mode_t;

	typedef struct packed {
		cell_mode_t mode;
		logic       cmp_en;
		logic       occupied;
	} cell_ctl_t;

endpackage : olm_pkg
`default_nettype wire

FILE: hdl/ordered_list_manager_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ordered_list_manager_unit
// bounded ordered list of signed 32-bit values kept in a row of shifting cells
// ----------------------------------------------------------------------------
//
// channel  dir  transfer contents
// s_*      in   request: tuser = req_type, tdata = value, key
// m_*      out  result:  tuser = status, tdata = element, tlast = last
//
// an update request runs as capture, compare in every cell,
// then shift/load in every cell at once with the status written out
// a dump runs the same steps, then sends one element at a time; the list rotates through
// cell 0 and is back in place when the last element leaves
// reset clears the length, dump counter, output valid, match flags and
// control state, not the cell values; those are never read beyond the length
// a stalled m_tready holds the apply and dump steps; one request is taken
// while the previous result still waits in the output register
//
module ordered_list_manager_unit #(
	parameter int CAPACITY = olm_pkg::OLM_CAPACITY
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// request stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [63:0] s_tdata,  // [31:0] value, [63:32] key
	input  wire logic [2:0]  s_tuser,  // [2:0] req_type
	// result stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [31:0] m_tdata,  // [31:0] element
	output logic      [1:0]  m_tuser,  // [1:0] status
	output logic             m_tlast
);
	import olm_pkg::*;

	localparam int LEN_W = $clog2(CAPACITY + 1);
	localparam int CNT_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	olm_state_t state_q, state_d;

	// captured request
	logic [OP_W-1:0]  op_q;
	logic [VAL_W-1:0] val_q;
	logic [VAL_W-1:0] key_q;

	logic [LEN_W-1:0] len_q;
	logic [CNT_W-1:0] cnt_q;

	// output register
	logic              out_valid_q;
	logic [STAT_W-1:0] out_stat_q;
	logic [VAL_W-1:0]  out_elem_q;
	logic              out_last_q;

	// fsm outputs
	logic in_ready, cmp_en, apply_en, dump_en;
	logic out_free;

	// cell row
	cell_ctl_t        ctl   [CAPACITY];
	logic [VAL_W-1:0] cval  [CAPACITY];
	logic [CAPACITY-1:0] match;
	logic [CAPACITY-1:0] pre_incl;   // a match at or below this cell
	logic [CAPACITY-1:0] pre_excl;   // a match strictly below this cell
	logic [VAL_W-1:0] search;

	logic full, empty, any_match, dump_last;

	assign out_free  = !out_valid_q || m_tready;
	assign full      = (len_q == LEN_W'(CAPACITY));
	assign empty     = (len_q == '0);
	assign any_match = pre_incl[CAPACITY-1];
	assign dump_last = (LEN_W'(cnt_q) == (len_q - LEN_W'(1)));
	assign search    = (op_q == OP_DEL_VALUE) ? val_q : key_q;

	// parallel prefix or over the match bits, log2 levels
	always_comb begin
		logic [CAPACITY-1:0] p;
		p = match;
		for (int s = 1; s < CAPACITY; s = s * 2) begin
			p = p | (p << s);
		end
		pre_incl = p;
		pre_excl = p << 1;
	end

	// ---- state machine ----
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (s_tvalid) state_d = ST_MATCH;
			ST_MATCH: state_d = ST_APPLY;
			ST_APPLY: begin
				if (out_free) begin
					state_d = (op_q == OP_DUMP && !empty) ? ST_DUMP : ST_IDLE;
				end
			end
			ST_DUMP:  if (out_free && dump_last) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmp_en   = 1'b0;
		apply_en = 1'b0;
		dump_en  = 1'b0;
		case (state_q)
			ST_IDLE:  in_ready = 1'b1;
			ST_MATCH: cmp_en   = 1'b1;
			ST_APPLY: apply_en = out_free;
			ST_DUMP:  dump_en  = out_free;
			default:  in_ready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// request capture, payload only
	always_ff @(posedge clk) begin
		if (in_ready && s_tvalid) begin
			op_q  <= s_tuser;
			val_q <= s_tdata[31:0];
			key_q <= s_tdata[63:32];
		end
	end

	// ---- length and dump counter ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			cnt_q <= '0;
		end else begin
			if (apply_en) begin
				cnt_q <= '0;
				case (op_q)
					OP_INS_FRONT, OP_INS_BACK: if (!full) len_q <= len_q + 1'b1;
					OP_INS_AFTER: if (!full && any_match) len_q <= len_q + 1'b1;
					OP_DEL_FRONT, OP_DEL_BACK: if (!empty) len_q <= len_q - 1'b1;
					OP_DEL_VALUE: if (any_match) len_q <= len_q - 1'b1;
					default: len_q <= len_q;
				endcase
			end else if (dump_en) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// ---- cell row ----
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic g_prev;
		logic [VAL_W-1:0] left_v, right_v;

		if (i == 0) begin : g_first
			assign g_prev = 1'b0;
			assign left_v = '0;
		end else begin : g_mid
			assign g_prev = pre_excl[i-1];
			assign left_v = cval[i-1];
		end

		if (i == CAPACITY - 1) begin : g_end
			assign right_v = cval[i];
		end else begin : g_nxt
			assign right_v = cval[i+1];
		end

		always_comb begin
			ctl[i].mode     = CM_HOLD;
			ctl[i].cmp_en   = cmp_en;
			ctl[i].occupied = (len_q > LEN_W'(i));
			if (apply_en) begin
				case (op_q)
					OP_INS_FRONT: begin
						if (!full) ctl[i].mode = (i == 0) ? CM_LOAD : CM_LEFT;
					end
					OP_INS_BACK: begin
						if (!full && len_q == LEN_W'(i)) ctl[i].mode = CM_LOAD;
					end
					OP_INS_AFTER: begin
						// new value goes just past the first matching cell
						if (!full) begin
							if (g_prev) ctl[i].mode = CM_LEFT;
							else if (pre_excl[i]) ctl[i].mode = CM_LOAD;
						end
					end
					OP_DEL_FRONT: begin
						if (!empty) ctl[i].mode = CM_RIGHT;
					end
					OP_DEL_VALUE: begin
						if (pre_incl[i]) ctl[i].mode = CM_RIGHT;
					end
					default: ctl[i].mode = CM_HOLD;
				endcase
			end else if (dump_en) begin
				// rotate: front element wraps to the back of the list
				if (len_q == LEN_W'(i + 1)) ctl[i].mode = CM_HEAD;
				else if (len_q > LEN_W'(i + 1)) ctl[i].mode = CM_RIGHT;
			end
		end

		olm_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl[i]),
			.search    (search),
			.new_val   (val_q),
			.left_val  (left_v),
			.right_val (right_v),
			.head_val  (cval[0]),
			.val       (cval[i]),
			.match     (match[i])
		);
	end

	// ---- result register ----
	logic [STAT_W-1:0] res_stat;

	always_comb begin
		res_stat = STAT_OK;
		case (op_q)
			OP_INS_FRONT, OP_INS_BACK: if (full) res_stat = STAT_FULL;
			OP_INS_AFTER: begin
				if (full) res_stat = STAT_FULL;
				else if (!any_match) res_stat = STAT_NOTFOUND;
			end
			OP_DEL_FRONT, OP_DEL_BACK, OP_DUMP: if (empty) res_stat = STAT_EMPTY;
			OP_DEL_VALUE: if (!any_match) res_stat = STAT_NOTFOUND;
			default: res_stat = STAT_OK;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (dump_en || (apply_en && !(op_q == OP_DUMP && !empty))) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (dump_en) begin
			out_stat_q <= STAT_OK;
			out_elem_q <= cval[0];
			out_last_q <= dump_last;
		end else if (apply_en) begin
			out_stat_q <= res_stat;
			out_elem_q <= '0;
			out_last_q <= 1'b1;
		end
	end

	assign s_tready = in_ready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_elem_q;
	assign m_tuser  = out_stat_q;
	assign m_tlast  = out_last_q;

`ifndef SYNTHESIS
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LEN_W'(CAPACITY))
		else $error("list length above capacity");

	a_len_step: assert property (@(posedge clk) disable iff (!arst_n)
		(len_q == $past(len_q)) || (len_q == $past(len_q) + 1'b1) ||
		(len_q == $past(len_q) - 1'b1))
		else $error("list length moved by more than one");

	a_dump_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DUMP) |=> $stable(len_q))
		else $error("list length changed during a dump");

	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != STAT_OK) |-> m_tlast)
		else $error("error status without last");
`endif

endmodule : ordered_list_manager_unit
`default_nettype wire

FILE: hdl/olm_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// olm_cell
// one list slot: holds a value, compares it, takes a new value, the head value or data from a neighbor
// ----------------------------------------------------------------------------
module olm_cell (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire olm_pkg::cell_ctl_t       ctl,
	input  wire logic [olm_pkg::VAL_W-1:0] search,
	input  wire logic [olm_pkg::VAL_W-1:0] new_val,
	input  wire logic [olm_pkg::VAL_W-1:0] left_val,
	input  wire logic [olm_pkg::VAL_W-1:0] right_val,
	input  wire logic [olm_pkg::VAL_W-1:0] head_val,
	output logic      [olm_pkg::VAL_W-1:0] val,
	output logic                          match
);
	import olm_pkg::*;

	logic [VAL_W-1:0] val_q;
	logic             match_q;

	always_ff @(posedge clk) begin
		case (ctl.mode)
			CM_LOAD:  val_q <= new_val;
			CM_LEFT:  val_q <= left_val;
			CM_RIGHT: val_q <= right_val;
			CM_HEAD:  val_q <= head_val;
			default:  val_q <= val_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else if (ctl.cmp_en) begin
			match_q <= ctl.occupied && (val_q == search);
		end
	end

	assign val   = val_q;
	assign match = match_q;

endmodule : olm_cell
`default_nettype wire
